@@ rtl/mpfc_pkg.sv @@
`default_nettype none
package mpfc_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;

   // points held per face: a, b, c, then midpoints ab, bc, ca
   localparam int NUM_POINTS = 6;
   localparam int NUM_COORDS = NUM_POINTS * 3;
   // face 0 is the original, faces 1 to 4 the split pieces
   localparam int NUM_FACES  = 5;
   localparam int NUM_PIECES = 4;

   localparam logic [2:0] PT_A  = 3'd0;
   localparam logic [2:0] PT_B  = 3'd1;
   localparam logic [2:0] PT_C  = 3'd2;
   localparam logic [2:0] PT_AB = 3'd3;
   localparam logic [2:0] PT_BC = 3'd4;
   localparam logic [2:0] PT_CA = 3'd5;

   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   // which point stands at vertex v of face f
   function automatic logic [2:0] face_point(input int f, input int v);
      logic [2:0] p;
      p = PT_A;
      case (f)
         0: p = (v == 0) ? PT_A  : (v == 1) ? PT_B  : PT_C;
         1: p = (v == 0) ? PT_A  : (v == 1) ? PT_AB : PT_CA;
         2: p = (v == 0) ? PT_AB : (v == 1) ? PT_B  : PT_BC;
         3: p = (v == 0) ? PT_CA : (v == 1) ? PT_BC : PT_C;
         4: p = (v == 0) ? PT_AB : (v == 1) ? PT_BC : PT_CA;
         default: p = PT_A;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

@@ rtl/mpfc_req_if.sv @@
`default_nettype none
interface mpfc_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
   logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
   logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/mpfc_rsp_if.sv @@
`default_nettype none
interface mpfc_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_a_x, out_a_y, out_a_z;
   logic signed [COORD_WIDTH-1:0] out_b_x, out_b_y, out_b_z;
   logic signed [COORD_WIDTH-1:0] out_c_x, out_c_y, out_c_z;
   logic                          is_piece;
   logic                          last_of_face;

   modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                   out_c_x, out_c_y, out_c_z, is_piece, last_of_face,
                   input ready);
   modport sink   (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                   out_c_x, out_c_y, out_c_z, is_piece, last_of_face,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/mpfc_energy.sv @@
`default_nettype none
// Two register stages: per-axis squares, then their sum.
module mpfc_energy
   import mpfc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          en_sq,
   input  wire logic                          en_sum,
   input  wire logic signed [COORD_WIDTH+2:0] diff [3],
   output      logic        [2*COORD_WIDTH+5:0] energy
);
   localparam int AW = COORD_WIDTH + 2;
   localparam int SW = 2 * AW;
   localparam int EW = 2 * COORD_WIDTH + 6;

   logic [AW-1:0] mag [3];
   logic [SW-1:0] sq_ff [3];
   logic [SW-1:0] sq_in [3];
   logic [EW-1:0] sum_ff;
   logic [EW-1:0] sum_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         // |diff| < 2^(W+2), fits after dropping the sign bit
         mag[j]   = diff[j][AW] ? AW'(-diff[j]) : diff[j][AW-1:0];
         sq_in[j] = SW'(mag[j]) * SW'(mag[j]);
      end
      sum_in = EW'(sq_ff[0]) + EW'(sq_ff[1]) + EW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en_sq) begin
         for (int j = 0; j < 3; j++) sq_ff[j] <= sq_in[j];
      end
      if (en_sum) sum_ff <= sum_in;
   end

   assign energy = sum_ff;
endmodule
`default_nettype wire

@@ rtl/mesh_perforation_face_classifier_unit.sv @@
`default_nettype none
// Channel   Direction  Carries
// req       in         one triangle, vertices a, b, c
// rsp       out        one kept face or split piece, with is_piece, last_of_face
// csr       in/out     APB registers center_x, center_y, center_z, radius
//
// A face passes four register stages (midpoints, centre offsets, squares, sums)
// and then the emit stage, which sends one result per cycle from the output register
// while the result port is not stalled. A kept face gives one result, a split face
// one result per surviving piece (up to 4), all through the single result port. Dropped faces send no result.
// Reset (synchronous) empties every stage and clears the registers.
// A stalled result port holds each stage in place; stages with bubbles still fill.
module mesh_perforation_face_classifier_unit
   import mpfc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int DATA_WIDTH  = (COORD_WIDTH > 32) ? 64 : 32,
   parameter int ADDR_WIDTH  = (COORD_WIDTH > 32) ? 5 : 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mpfc_req_if.sink                   req,
   mpfc_rsp_if.source                 rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_WIDTH-1:0] paddr,
   input  wire logic [DATA_WIDTH-1:0] pwdata,
   output      logic [DATA_WIDTH-1:0] prdata,
   output      logic                  pready
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 3;
   localparam int EW = 2 * W + 6;
   localparam int RW = 2 * W - 2;
   localparam int NS = 4;

   typedef logic [NUM_COORDS-1:0][W-1:0] pts_type;

   // ---------------- registers
   logic signed [W-1:0] center_ff [3];
   logic        [W-2:0] radius_ff;
   logic signed [W+1:0] c3_ff [3];
   logic        [RW-1:0] r2_ff;
   logic        [EW-1:0] inner_ff, outer_ff;
   logic        [1:0]   reg_idx;
   logic                csr_write;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_WIDTH-1 -: 2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) center_ff[j] <= '0;
         radius_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_CENTER_X: center_ff[0] <= pwdata[W-1:0];
            REG_CENTER_Y: center_ff[1] <= pwdata[W-1:0];
            REG_CENTER_Z: center_ff[2] <= pwdata[W-1:0];
            REG_RADIUS:   radius_ff    <= pwdata[W-2:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CENTER_X: prdata = DATA_WIDTH'(center_ff[0]);
         REG_CENTER_Y: prdata = DATA_WIDTH'(center_ff[1]);
         REG_CENTER_Z: prdata = DATA_WIDTH'(center_ff[2]);
         REG_RADIUS:   prdata = DATA_WIDTH'(radius_ff);
         default:      prdata = '0;
      endcase
   end

   // derived constants are registered; user must make writes only when idle, unenforced
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         c3_ff[j] <= ((W+2)'(center_ff[j]) <<< 1) + (W+2)'(center_ff[j]);
      end
      r2_ff    <= RW'(radius_ff) * RW'(radius_ff);
      inner_ff <= (EW'(r2_ff) << 3) + EW'(r2_ff);
      outer_ff <= (EW'(r2_ff) << 5) + (EW'(r2_ff) << 2);
   end

   // ---------------- pipeline control
   logic [NS-1:0] v_ff;
   logic [NS-1:0] ld;
   logic          ex_free, take4;

   always_comb begin
      ld[NS-1] = !v_ff[NS-1] || ex_free;
      for (int k = NS - 2; k >= 0; k--) ld[k] = !v_ff[k] || ld[k+1];
   end
   assign take4     = v_ff[NS-1] && ex_free;
   assign req.ready = ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[0]) v_ff[0] <= req.valid;
         for (int k = 1; k < NS; k++) begin
            if (ld[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // ---------------- stage 1: vertices and floored midpoints
   pts_type p1_in, p1_ff, p2_ff, p3_ff, p4_ff;
   logic [W:0] msum;

   always_comb begin
      p1_in[0] = req.a_x;  p1_in[1] = req.a_y;  p1_in[2] = req.a_z;
      p1_in[3] = req.b_x;  p1_in[4] = req.b_y;  p1_in[5] = req.b_z;
      p1_in[6] = req.c_x;  p1_in[7] = req.c_y;  p1_in[8] = req.c_z;
      msum = '0;
      for (int j = 0; j < 3; j++) begin
         msum = {p1_in[j][W-1], p1_in[j]} + {p1_in[3+j][W-1], p1_in[3+j]};
         p1_in[9+j] = msum[W:1];
         msum = {p1_in[3+j][W-1], p1_in[3+j]} + {p1_in[6+j][W-1], p1_in[6+j]};
         p1_in[12+j] = msum[W:1];
         msum = {p1_in[6+j][W-1], p1_in[6+j]} + {p1_in[j][W-1], p1_in[j]};
         p1_in[15+j] = msum[W:1];
      end
   end

   // ---------------- stage 2: per-face offsets a+b+c-3*center
   logic signed [DW-1:0] d2_in [NUM_FACES][3];
   logic signed [DW-1:0] d2_ff [NUM_FACES][3];

   always_comb begin
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int j = 0; j < 3; j++) begin
            d2_in[f][j] = DW'($signed(p1_ff[face_point(f, 0)*3 + j]))
                        + DW'($signed(p1_ff[face_point(f, 1)*3 + j]))
                        + DW'($signed(p1_ff[face_point(f, 2)*3 + j]))
                        - DW'(c3_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) p1_ff <= p1_in;
      if (ld[1]) begin
         p2_ff <= p1_ff;
         d2_ff <= d2_in;
      end
      if (ld[2]) p3_ff <= p2_ff;
      if (ld[3]) p4_ff <= p3_ff;
   end

   // ---------------- stages 3 and 4: squares and sums
   logic [EW-1:0] e4 [NUM_FACES];

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_energy
      mpfc_energy #(.COORD_WIDTH(COORD_WIDTH)) u_energy (
         .clock  (clock),
         .en_sq  (ld[2]),
         .en_sum (ld[3]),
         .diff   (d2_ff[f]),
         .energy (e4[f])
      );
   end

   logic                  pass4, drop4;
   logic [NUM_PIECES-1:0] mask4;

   always_comb begin
      pass4 = e4[0] > outer_ff;
      drop4 = e4[0] < inner_ff;
      for (int k = 0; k < NUM_PIECES; k++) begin
         mask4[k] = !pass4 && !drop4 && (e4[k+1] >= inner_ff);
      end
   end

   // ---------------- emit stage: one result a cycle unless the result port stalls
   logic                  ex_valid_ff;
   logic                  ex_pass_ff;
   logic [NUM_PIECES-1:0] ex_mask_ff;
   pts_type               ex_pts_ff;
   logic                  load_out, emit, ex_finish;
   logic [NUM_PIECES-1:0] pick, remain;
   int                    face;

   logic                  rsp_valid_ff;
   logic [8:0][W-1:0]     rsp_face_ff, rsp_face_in;
   logic                  rsp_piece_ff, rsp_last_ff;

   assign load_out = !rsp_valid_ff || rsp.ready;
   assign emit     = ex_valid_ff && load_out;

   always_comb begin
      pick = ex_mask_ff & (~ex_mask_ff + 1'b1);
      remain = ex_mask_ff & ~pick;
      face = 0;
      if (!ex_pass_ff) begin
         for (int k = NUM_PIECES - 1; k >= 0; k--) begin
            if (pick[k]) face = k + 1;
         end
      end
      for (int v = 0; v < 3; v++) begin
         for (int j = 0; j < 3; j++) begin
            rsp_face_in[v*3 + j] = ex_pts_ff[face_point(face, v)*3 + j];
         end
      end
   end

   assign ex_finish = emit && (ex_pass_ff || remain == '0);
   assign ex_free   = !ex_valid_ff || ex_finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take4) begin
            ex_valid_ff <= pass4 || (mask4 != '0);
         end else if (ex_finish) begin
            ex_valid_ff <= 1'b0;
         end
         if (load_out) rsp_valid_ff <= ex_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take4) begin
         ex_pts_ff  <= p4_ff;
         ex_pass_ff <= pass4;
         ex_mask_ff <= mask4;
      end else if (emit) begin
         ex_mask_ff <= remain;
      end
      if (emit) begin
         rsp_face_ff  <= rsp_face_in;
         rsp_piece_ff <= !ex_pass_ff;
         rsp_last_ff  <= ex_pass_ff || (remain == '0);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_a_x      = rsp_face_ff[0];
   assign rsp.out_a_y      = rsp_face_ff[1];
   assign rsp.out_a_z      = rsp_face_ff[2];
   assign rsp.out_b_x      = rsp_face_ff[3];
   assign rsp.out_b_y      = rsp_face_ff[4];
   assign rsp.out_b_z      = rsp_face_ff[5];
   assign rsp.out_c_x      = rsp_face_ff[6];
   assign rsp.out_c_y      = rsp_face_ff[7];
   assign rsp.out_c_z      = rsp_face_ff[8];
   assign rsp.is_piece     = rsp_piece_ff;
   assign rsp.last_of_face = rsp_last_ff;

   // ---------------- checks
   a_ex_has_work: assert property (@(posedge clock) disable iff (reset)
      ex_valid_ff |-> (ex_pass_ff || ex_mask_ff != '0))
      else $error("emit stage holds a face with nothing to send");

   a_kept_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.is_piece) |-> rsp.last_of_face)
      else $error("kept face not marked last");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (v_ff == {NS{1'b1}}))
      else $error("input stalled with a bubble in the pipe");

   a_finish_frees: assert property (@(posedge clock) disable iff (reset)
      (ex_finish && !take4) |=> !ex_valid_ff)
      else $error("emit stage not freed after its last result");
endmodule
`default_nettype wire
